/* rtl/rfbd_pkg.sv */
// Shared types and codes for the ring FIFO with bulk discard.
`timescale 1ns / 1ps

package rfbd_pkg;

  // Request codes carried on req_type
  typedef enum logic [2:0] {
    REQ_PUSH    = 3'd0,
    REQ_PEEK    = 3'd1,
    REQ_POP     = 3'd2,
    REQ_DISCARD = 3'd3,
    REQ_CLEAR   = 3'd4
  } req_t;

  // Status codes reported with every result
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_POP  = 1'b1
  } fsm_t;

endpackage

/* rtl/ring_fifo_with_bulk_discard_top.sv */
// Top level of the ring FIFO with bulk discard: controller and item memory.
`timescale 1ns / 1ps

// Ring FIFO, DEPTH items of ITEM_WIDTH bits, with push, peek, pop, discard
// and clear requests.
// Requests: a beat is taken on the rising edge where start is high and busy
// is low; req_type, push_item and req_count are sampled on that edge.
// Results: each beat shows for one cycle with strobe high and cannot be held
// off. Every request gives its first result beat in the cycle after it is
// taken. Push, peek, discard, clear and pop of at most one item give a single
// beat and leave busy low, so these stream at one request per clock.
// A pop of N items gives N beats on consecutive cycles, the last one marked
// by last_of_run; busy stays high while the memory read port walks the
// remaining entries, one read per cycle. occupancy and moved_count already
// show the state after the whole request from the first beat.
// Peek and pop data come from the registered read port of the item memory.
// Reset (rst, synchronous) empties the store and drops strobe and busy; the
// item memory itself is not cleared and needs no sweep.

module ring_fifo_with_bulk_discard_top #(
  parameter int DEPTH      = 1024,
  parameter int ITEM_WIDTH = 32,
  parameter int MAX_BURST  = 16,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int MW        = $clog2(MAX_BURST + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            req_type,
  input  logic [ITEM_WIDTH-1:0] push_item,
  input  logic [4:0]            req_count,
  output logic                  strobe,
  output logic [ITEM_WIDTH-1:0] out_item,
  output logic                  item_valid,
  output logic                  last_of_run,
  output logic [1:0]            status,
  output logic [CW-1:0]         occupancy,
  output logic [MW-1:0]         moved_count
);

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ITEM_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [ITEM_WIDTH-1:0] ram_rdata;

  rfbd_ctrl #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH),
    .MAX_BURST  (MAX_BURST)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .push_item   (push_item),
    .req_count   (req_count),
    .strobe      (strobe),
    .item_valid  (item_valid),
    .last_of_run (last_of_run),
    .status      (status),
    .occupancy   (occupancy),
    .moved_count (moved_count),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr)
  );

  rfbd_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // item word only on beats that carry a stored item
  assign out_item = item_valid ? ram_rdata : '0;

endmodule

/* rtl/rfbd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rfbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/rfbd_ctrl.sv */
// Request controller: read position, occupancy, pop sequencer and result registers.
`timescale 1ns / 1ps

module rfbd_ctrl
  import rfbd_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int ITEM_WIDTH = 32,
  parameter int MAX_BURST  = 16,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int MW        = $clog2(MAX_BURST + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  // request side
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            req_type,
  input  logic [ITEM_WIDTH-1:0] push_item,
  input  logic [4:0]            req_count,
  // result side
  output logic                  strobe,
  output logic                  item_valid,
  output logic                  last_of_run,
  output logic [1:0]            status,
  output logic [CW-1:0]         occupancy,
  output logic [MW-1:0]         moved_count,
  // item memory
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [ITEM_WIDTH-1:0] ram_wdata,
  output logic                  ram_re,
  output logic [AW-1:0]         ram_raddr
);

  localparam int SW = AW + 1;
  localparam int KW = (CW > 7) ? CW : 7;

  fsm_t            state, state_next;
  logic [AW-1:0]   rd_pos, rd_pos_next;
  logic [CW-1:0]   item_count, item_count_next;
  logic [AW-1:0]   pop_addr;
  logic [MW-1:0]   pop_left;

  logic            res_strobe;
  logic            res_read;
  logic            res_last;
  status_t         res_status;
  logic [CW-1:0]   res_occ;
  logic [MW-1:0]   res_moved;

  logic            accept;
  logic            is_full;
  logic            is_empty;
  logic [KW-1:0]   want;
  logic [MW-1:0]   take;
  logic [SW-1:0]   wsum;
  logic [SW-1:0]   asum;
  logic [AW-1:0]   adv_pos;
  logic [AW-1:0]   next_addr;
  logic [AW-1:0]   rd_pos_inc;

  assign accept   = start && !busy;
  assign is_full  = (item_count == CW'(DEPTH));
  assign is_empty = (item_count == '0);

  // clip the requested count to the burst limit and the occupancy
  always_comb begin
    want = KW'(req_count);
    if (want > KW'(MAX_BURST)) begin
      want = KW'(MAX_BURST);
    end
    if (want > KW'(item_count)) begin
      want = KW'(item_count);
    end
    take = MW'(want);
  end

  // write slot after the newest item, and the read position after a move
  always_comb begin
    wsum      = SW'(rd_pos) + SW'(item_count);
    ram_waddr = (wsum >= SW'(DEPTH)) ? AW'(wsum - SW'(DEPTH)) : AW'(wsum);
    asum      = SW'(rd_pos) + SW'(take);
    adv_pos   = (asum >= SW'(DEPTH)) ? AW'(asum - SW'(DEPTH)) : AW'(asum);
  end

  // pointer increments with wrap
  assign next_addr  = (pop_addr == AW'(DEPTH - 1)) ? '0 : pop_addr + 1'b1;
  assign rd_pos_inc = (rd_pos == AW'(DEPTH - 1)) ? '0 : rd_pos + 1'b1;

  assign ram_we    = accept && (req_type == REQ_PUSH) && !is_full;
  assign ram_wdata = push_item;

  // position and occupancy update, all applied when the request is taken
  always_comb begin
    rd_pos_next     = rd_pos;
    item_count_next = item_count;
    if (accept) begin
      unique case (req_type)
        REQ_PUSH: begin
          if (!is_full) begin
            item_count_next = item_count + 1'b1;
          end
        end
        REQ_POP, REQ_DISCARD: begin
          rd_pos_next     = adv_pos;
          item_count_next = item_count - CW'(take);
        end
        REQ_CLEAR: begin
          rd_pos_next     = '0;
          item_count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (accept && (req_type == REQ_POP) && (take > MW'(1))) begin
          state_next = FSM_POP;
        end
      end
      FSM_POP: begin
        if (pop_left == MW'(1)) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  // state outputs: handshake and memory read port
  always_comb begin
    busy      = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rd_pos;
    unique case (state)
      FSM_IDLE: begin
        ram_re = accept &&
                 (((req_type == REQ_PEEK) && !is_empty) ||
                  ((req_type == REQ_POP) && (take != '0)));
      end
      FSM_POP: begin
        busy      = 1'b1;
        ram_re    = 1'b1;
        ram_raddr = pop_addr;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FSM_IDLE;
      rd_pos     <= '0;
      item_count <= '0;
      res_strobe <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pos     <= rd_pos_next;
      item_count <= item_count_next;
      res_strobe <= accept || (state == FSM_POP);
    end
  end

  // result beat and pop sequencer
  always_ff @(posedge clk) begin
    if (accept) begin
      res_occ    <= item_count_next;
      res_read   <= 1'b0;
      res_last   <= 1'b1;
      res_status <= ST_OK;
      res_moved  <= '0;
      pop_addr   <= rd_pos_inc;
      pop_left   <= take - 1'b1;
      unique case (req_type)
        REQ_PUSH: begin
          if (is_full) begin
            res_status <= ST_FULL;
          end
        end
        REQ_PEEK: begin
          res_read   <= !is_empty;
          res_status <= is_empty ? ST_EMPTY : ST_OK;
        end
        REQ_POP: begin
          res_status <= is_empty ? ST_EMPTY : ST_OK;
          res_moved  <= take;
          res_read   <= (take != '0);
          res_last   <= (take <= MW'(1));
        end
        REQ_DISCARD: begin
          res_status <= is_empty ? ST_EMPTY : ST_OK;
          res_moved  <= take;
        end
        default: begin
        end
      endcase
    end else if (state == FSM_POP) begin
      // one more popped item; occupancy and count stay as reported
      res_read <= 1'b1;
      res_last <= (pop_left == MW'(1));
      pop_left <= pop_left - 1'b1;
      pop_addr <= next_addr;
    end
  end

  assign strobe      = res_strobe;
  assign item_valid  = res_strobe && res_read;
  assign last_of_run = res_last;
  assign status      = res_status;
  assign occupancy   = res_occ;
  assign moved_count = res_moved;

endmodule

/* rtl/rfbd_checker.sv */
// Port-level assertions for the ring FIFO top level, bound to it.
`timescale 1ns / 1ps

module rfbd_checker
  import rfbd_pkg::*;
#(
  parameter int ITEM_WIDTH = 32,
  parameter int CW         = 11,
  parameter int MW         = 5
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  strobe,
  input logic [ITEM_WIDTH-1:0] out_item,
  input logic                  item_valid,
  input logic                  last_of_run,
  input logic [1:0]            status,
  input logic [CW-1:0]         occupancy,
  input logic [MW-1:0]         moved_count
);

  // reset leaves no beat pending and the request side open
  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe && !busy)
    else $error("beat or busy after reset");

  // every request taken gives a result beat on the next cycle
  a_req_answered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> strobe)
    else $error("request without a result beat");

  // a beat that is not the last is followed by another of the same run
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_of_run) |=>
      (strobe && item_valid && $stable(occupancy) && $stable(moved_count)))
    else $error("pop run broken off");

  // while a pop run is in flight the shown beat is a popped item, not the last
  a_busy_in_run: assert property (@(posedge clk) disable iff (rst)
    busy |-> (strobe && item_valid && !last_of_run && (status == ST_OK)))
    else $error("busy outside a pop run");

  // item word reads as zero unless it carries a stored item
  a_item_zero: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> (out_item == '0))
    else $error("item word without a valid item");

endmodule

bind ring_fifo_with_bulk_discard_top rfbd_checker #(
  .ITEM_WIDTH (ITEM_WIDTH),
  .CW         (CW),
  .MW         (MW)
) u_rfbd_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .strobe      (strobe),
  .out_item    (out_item),
  .item_valid  (item_valid),
  .last_of_run (last_of_run),
  .status      (status),
  .occupancy   (occupancy),
  .moved_count (moved_count)
);

/* sim/tb_ring_fifo_with_bulk_discard_top.sv */
// Self-checking testbench for the ring FIFO with bulk discard.
`timescale 1ns / 1ps

module tb_ring_fifo_with_bulk_discard_top;
  import rfbd_pkg::*;

  localparam int FIFO_DEPTH = 1024;
  localparam int BURST_MAX  = 16;
  localparam int RAND_REQS  = 300;
  localparam int SHOW_MAX   = 100;

  // One result beat as the block should show it
  typedef struct {
    logic [31:0] item;
    logic        valid;
    logic        last;
    logic [1:0]  st;
    logic [10:0] occ;
    logic [4:0]  moved;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  req_type;
  logic [31:0] push_item;
  logic [4:0]  req_count;
  logic        strobe;
  logic [31:0] out_item;
  logic        item_valid;
  logic        last_of_run;
  logic [1:0]  status;
  logic [10:0] occupancy;
  logic [4:0]  moved_count;

  // Shadow FIFO kept by the predictor
  logic [31:0] shadow_mem [FIFO_DEPTH];
  logic [9:0]  shadow_head;
  logic [10:0] shadow_fill;

  beat_t expected_beats[$];
  int    mismatch_count = 0;
  int    burst_left = 0;

  ring_fifo_with_bulk_discard_top DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .push_item   (push_item),
    .req_count   (req_count),
    .strobe      (strobe),
    .out_item    (out_item),
    .item_valid  (item_valid),
    .last_of_run (last_of_run),
    .status      (status),
    .occupancy   (occupancy),
    .moved_count (moved_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // One line per mismatch; quiet after the first hundred
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < SHOW_MAX)
      $display("%0t: %s got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic beat_t make_beat(input logic [31:0] item, input logic valid,
                                      input logic last, input status_t st,
                                      input logic [4:0] moved);
    beat_t b;
    b.item  = item;
    b.valid = valid;
    b.last  = last;
    b.st    = st;
    b.occ   = shadow_fill;
    b.moved = moved;
    return b;
  endfunction

  // Clip a pop/discard count to the burst limit and the fill level
  function automatic logic [4:0] clipped_count(input logic [4:0] c);
    int n;
    n = c;
    if (n > BURST_MAX) n = BURST_MAX;
    if (n > shadow_fill) n = shadow_fill;
    return n[4:0];
  endfunction

  // Apply one accepted request to the shadow FIFO and queue its beats
  task automatic predict_fifo_beats(input logic [2:0] t, input logic [31:0] d,
                                    input logic [4:0] c);
    logic [4:0] n;
    logic [9:0] first;
    logic       was_empty;
    was_empty = (shadow_fill == 0);
    n = clipped_count(c);
    case (t)
      REQ_PUSH: begin
        if (shadow_fill >= FIFO_DEPTH) begin
          expected_beats.push_back(make_beat(32'd0, 1'b0, 1'b1, ST_FULL, 5'd0));
        end else begin
          shadow_mem[10'(shadow_head + shadow_fill)] = d;
          shadow_fill = shadow_fill + 1'b1;
          expected_beats.push_back(make_beat(32'd0, 1'b0, 1'b1, ST_OK, 5'd0));
        end
      end
      REQ_PEEK: begin
        if (was_empty)
          expected_beats.push_back(make_beat(32'd0, 1'b0, 1'b1, ST_EMPTY, 5'd0));
        else
          expected_beats.push_back(make_beat(shadow_mem[shadow_head], 1'b1, 1'b1,
                                             ST_OK, 5'd0));
      end
      REQ_POP: begin
        if (n == 0) begin
          expected_beats.push_back(make_beat(32'd0, 1'b0, 1'b1,
                                             was_empty ? ST_EMPTY : ST_OK, 5'd0));
        end else begin
          first = shadow_head;
          shadow_head = shadow_head + n;
          shadow_fill = shadow_fill - n;
          for (int i = 0; i < n; i++)
            expected_beats.push_back(make_beat(shadow_mem[10'(first + i)], 1'b1,
                                               (i + 1 == n), ST_OK, n));
        end
      end
      REQ_DISCARD: begin
        shadow_head = shadow_head + n;
        shadow_fill = shadow_fill - n;
        expected_beats.push_back(make_beat(32'd0, 1'b0, 1'b1,
                                           was_empty ? ST_EMPTY : ST_OK, n));
      end
      REQ_CLEAR: begin
        shadow_head = '0;
        shadow_fill = '0;
        expected_beats.push_back(make_beat(32'd0, 1'b0, 1'b1, ST_OK, 5'd0));
      end
      default: begin
        // codes five to seven do nothing
        expected_beats.push_back(make_beat(32'd0, 1'b0, 1'b1, ST_OK, 5'd0));
      end
    endcase
  endtask

  // Drive one request from a falling edge, hold until taken; start stays high
  task automatic send_req(input logic [2:0] t, input logic [31:0] d,
                          input logic [4:0] c);
    start     <= 1'b1;
    req_type  <= t;
    push_item <= d;
    req_count <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_fifo_beats(t, d, c);
    @(negedge clk);
  endtask

  // Sender pacing: random bursts, random gaps, now and then a long stretch
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(0, 12);
    end
  endtask

  // Hold the sender off until every queued beat has come
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    beat_t want;
    if (!rst && strobe) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat, out_item", out_item, 32'd0);
      end else begin
        want = expected_beats.pop_front();
        if (out_item !== want.item)
          report_mismatch("out_item", out_item, want.item);
        if (item_valid !== want.valid)
          report_mismatch("item_valid", item_valid, want.valid);
        if (last_of_run !== want.last)
          report_mismatch("last_of_run", last_of_run, want.last);
        if (status !== want.st)
          report_mismatch("status", status, want.st);
        if (occupancy !== want.occ)
          report_mismatch("occupancy", occupancy, want.occ);
        if (moved_count !== want.moved)
          report_mismatch("moved_count", moved_count, want.moved);
      end
    end
  end

  // Empty-store cases, data extremes, every request code, clipping to fill
  task automatic test_directed_edges();
    send_req(REQ_PEEK, 32'hDEAD_BEEF, 5'd0);
    send_req(REQ_POP, 32'd0, 5'd5);
    send_req(REQ_DISCARD, 32'd0, 5'd31);
    send_req(REQ_PUSH, 32'h0000_0000, 5'd0);
    send_req(REQ_PUSH, 32'hFFFF_FFFF, 5'd31);
    send_req(REQ_PUSH, 32'h5555_5555, 5'd0);
    send_req(REQ_PUSH, 32'hAAAA_AAAA, 5'd0);
    send_req(REQ_PEEK, 32'd0, 5'd0);
    send_req(REQ_POP, 32'd0, 5'd0);
    send_req(REQ_DISCARD, 32'd0, 5'd0);
    send_req(REQ_POP, 32'd0, 5'd1);
    send_req(3'd5, 32'hFFFF_FFFF, 5'd31);
    send_req(3'd6, 32'h1234_5678, 5'd16);
    send_req(3'd7, 32'h8765_4321, 5'd7);
    send_req(REQ_POP, 32'd0, 5'd31);
    send_req(REQ_PUSH, 32'h0F0F_0F0F, 5'd0);
    send_req(REQ_PUSH, 32'hF0F0_F0F0, 5'd0);
    send_req(REQ_PUSH, 32'h8000_0001, 5'd0);
    send_req(REQ_DISCARD, 32'd0, 5'd2);
    send_req(REQ_PEEK, 32'd0, 5'd0);
    send_req(REQ_CLEAR, 32'hFFFF_FFFF, 5'd31);
    send_req(REQ_PEEK, 32'd0, 5'd0);
    send_req(REQ_PUSH, 32'h7FFF_FFFE, 5'd0);
    send_req(REQ_PEEK, 32'd0, 5'd0);
    send_req(REQ_POP, 32'd0, 5'd2);
    wait_drained();
  endtask

  // Fill to the top, push into a full store, then drain so both ends wrap
  task automatic test_full_and_wrap();
    while (shadow_fill < FIFO_DEPTH) begin
      send_req(REQ_PUSH, $urandom, 5'($urandom));
      pace_sender();
    end
    send_req(REQ_PUSH, 32'hFFFF_FFFF, 5'd0);
    send_req(REQ_PUSH, 32'h0000_0000, 5'd0);
    send_req(REQ_PEEK, 32'd0, 5'd0);
    send_req(REQ_POP, 32'd0, 5'd31);
    send_req(REQ_POP, 32'd0, 5'd17);
    for (int i = 0; i < 32; i++) begin
      send_req(REQ_PUSH, $urandom, 5'd0);
      pace_sender();
    end
    send_req(REQ_PUSH, 32'h0000_0001, 5'd0);
    while (shadow_fill > 40) begin
      send_req(REQ_DISCARD, 32'd0, ($urandom_range(0, 1) == 0) ? 5'd31 : 5'd16);
      pace_sender();
    end
    while (shadow_fill > 0) begin
      send_req(REQ_POP, 32'd0, 5'($urandom_range(1, 31)));
      pace_sender();
    end
    send_req(REQ_PEEK, 32'd0, 5'd0);
    send_req(REQ_DISCARD, 32'd0, 5'd16);
    wait_drained();
  endtask

  // Random mix, push-heavy while the store is low, with the result beats drained once midway
  task automatic test_random_mix();
    int pick;
    logic [2:0]  t;
    logic [4:0]  c;
    for (int k = 0; k < RAND_REQS; k++) begin
      pick = $urandom_range(0, 99);
      c = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 16));
      if (pick < 40 || (shadow_fill < 4 && pick < 60)) t = REQ_PUSH;
      else if (pick < 55) t = REQ_PEEK;
      else if (pick < 78) t = REQ_POP;
      else if (pick < 90) t = REQ_DISCARD;
      else if (pick < 94) t = REQ_CLEAR;
      else t = 3'($urandom_range(5, 7));
      send_req(t, $urandom, c);
      if (k == RAND_REQS / 2) wait_drained();
      else pace_sender();
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    req_type  = '0;
    push_item = '0;
    req_count = '0;
    shadow_head = '0;
    shadow_fill = '0;
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_edges();
    test_full_and_wrap();
    test_random_mix();

    // Let the last beats arrive, bounded
    start <= 1'b0;
    for (int w = 0; w < 2000 && expected_beats.size() != 0; w++) @(negedge clk);
    if (expected_beats.size() != 0)
      report_mismatch("beats never seen, count", expected_beats.size(), 32'd0);
    repeat (40) @(negedge clk);

    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
